FILE: hw/rtl/legendre_moment_expansion_assert.svh
// Assertion macros used by the Legendre moment expansion top level.
`ifndef LEGENDRE_MOMENT_EXPANSION_ASSERT_SVH
`define LEGENDRE_MOMENT_EXPANSION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LME_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lme_pkg.sv
// Shared types and constants of the Legendre moment expansion block.
package lme_pkg;

    localparam int MAX_COEFFS_DEF = 64;

    localparam int CFG_W    = 7;
    localparam int PHASE_W  = 32;
    localparam int COS_W    = 32;
    localparam int WEIGHT_W = 32;
    localparam int ACC_W    = 56;
    localparam int P_W      = 32;
    localparam int OUT_W    = 48;
    localparam int IDX_W    = 6;
    localparam int PW_W     = 64;
    localparam int FACT_W   = 41;
    localparam int TERM_W   = 44;
    localparam int T_W      = 34;
    localparam int QUO_W    = 32;

    localparam logic [CFG_W-1:0]  CFG_RESET = 7'd64;
    localparam logic signed [P_W-1:0] P_ONE   = 32'sh4000_0000;
    localparam logic signed [P_W-1:0] P_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [P_W-1:0] P_MIN   = 32'sh8000_0000;
    localparam logic [OUT_W-1:0]  OUT_MAX   = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FACT,
        S_ROUND,
        S_RD,
        S_MUL,
        S_ACC,
        S_NUM,
        S_DIV,
        S_ERD,
        S_EMUL,
        S_EOUT
    } t_state;

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHECK,
        D_RUN
    } t_div_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_all;
    } t_mem_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: hw/rtl/lme_acc_mem.sv
// Accumulator memory with registered read and per-entry valid bits.
module lme_acc_mem #(
    parameter int DEPTH = lme_pkg::MAX_COEFFS_DEF,
    parameter int AW    = $clog2(lme_pkg::MAX_COEFFS_DEF)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lme_pkg::t_mem_ctl               i_ctl,
    input  logic [AW-1:0]                   i_addr,
    input  logic signed [lme_pkg::ACC_W-1:0] i_wr_data,
    output logic signed [lme_pkg::ACC_W-1:0] o_rd_data
);
    import lme_pkg::*;

    logic signed [ACC_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]        r_valid;
    logic signed [ACC_W-1:0] r_rd_data;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    // An entry that was never written since reset or the last clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.rd_en) begin
                r_rd_valid <= r_valid[i_addr];
            end
            if (i_ctl.clr_all) begin
                r_valid <= '0;
            end else if (i_ctl.wr_en) begin
                r_valid[i_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: hw/rtl/lme_div.sv
// Bit-serial divider for the recurrence quotient, saturated to 32 bits.
module lme_div #(
    parameter int NUM_W = 42,
    parameter int CNT_W = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [NUM_W-1:0]                i_dividend,
    input  logic [CNT_W-1:0]                i_divisor,
    input  logic                            i_neg,
    output lme_pkg::t_div_stat              o_stat,
    output logic signed [lme_pkg::P_W-1:0]  o_quot
);
    import lme_pkg::*;

    t_div_state        r_state;
    t_div_state        n_state;
    logic [NUM_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_d;
    logic              r_neg;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_low;
    logic [QUO_W-1:0]  r_quo;
    logic [4:0]        r_cnt;
    logic              r_done;

    logic              ovf_now;
    logic [CNT_W:0]    rem2;
    logic              ge;

    // The quotient has 32 bits; a larger one only saturates.
    assign ovf_now = r_dvd >= (NUM_W'(r_d) << QUO_W);
    assign rem2    = {r_rem, r_low[QUO_W-1]};
    assign ge      = rem2 >= {1'b0, r_d};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE:  if (i_start) n_state = D_CHECK;
            D_CHECK: n_state = ovf_now ? D_IDLE : D_RUN;
            D_RUN:   if (r_cnt == 5'd0) n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_comb begin
        o_stat.busy = (r_state != D_IDLE);
        o_stat.done = r_done;
        if (!r_neg) begin
            o_quot = (r_ovf || r_quo[QUO_W-1]) ? P_MAX : $signed(r_quo);
        end else begin
            o_quot = (r_ovf || r_quo > 32'h8000_0000) ? P_MIN : $signed(-r_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ((r_state == D_CHECK) && ovf_now) ||
                       ((r_state == D_RUN) && (r_cnt == 5'd0));
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_dvd <= i_dividend;
                    r_d   <= i_divisor;
                    r_neg <= i_neg;
                end
            end
            D_CHECK: begin
                r_ovf <= ovf_now;
                r_rem <= CNT_W'(r_dvd >> QUO_W);
                r_low <= r_dvd[QUO_W-1:0];
                r_quo <= '0;
                r_cnt <= 5'd31;
            end
            D_RUN: begin
                r_rem <= ge ? CNT_W'(rem2 - {1'b0, r_d}) : CNT_W'(rem2);
                r_quo <= {r_quo[QUO_W-2:0], ge};
                r_low <= {r_low[QUO_W-2:0], 1'b0};
                r_cnt <= r_cnt - 5'd1;
            end
            default: begin
                r_ovf <= r_ovf;
            end
        endcase
    end

endmodule

FILE: hw/rtl/legendre_moment_expansion.sv
// Top level of the Legendre moment expansion block.
// Each input item is one quadrature point. The block runs the three-term
// Legendre recurrence over orders 0..n-1 (n = coefficient_count, with zero
// taken as one and values above MAX_COEFFS taken as MAX_COEFFS) and adds
// phase*weight*P_k into accumulator k, held in an on-chip memory that is
// read, updated and written back once per order. Each order but the last
// waits on a bit-serial divider that produces one quotient bit per cycle for
// the recurrence division by k+1, which sets the rate. The point marked last
// then emits n coefficients, each passing through S_ERD, S_EMUL and S_EOUT
// and held in S_EOUT while the output is stalled, and clears all accumulators
// at once. No item is taken during a point's run or emission.
module legendre_moment_expansion #(
    parameter int MAX_COEFFS = lme_pkg::MAX_COEFFS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [lme_pkg::CFG_W-1:0]           i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lme_pkg::PHASE_W-1:0]         i_phase_value,
    input  logic signed [lme_pkg::COS_W-1:0]    i_node_cosine,
    input  logic [lme_pkg::WEIGHT_W-1:0]        i_node_weight,
    input  logic                                i_last_point,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [lme_pkg::OUT_W-1:0]           o_coefficient_value,
    output logic [lme_pkg::IDX_W-1:0]           o_coefficient_index,
    output logic                                o_last_coefficient
);
    import lme_pkg::*;

    `include "legendre_moment_expansion_assert.svh"

    localparam int KW     = $clog2(MAX_COEFFS);
    localparam int CNT_W  = $clog2(MAX_COEFFS + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int NUM_W  = T_W + KW + 2;
    localparam int EP_W   = ACC_W - 1 + KW + 1;
    localparam int SUM_W  = ACC_W + 1;

    t_state                  r_state;
    t_state                  n_state;
    logic [CFG_W-1:0]        r_cfg_count;
    logic [PHASE_W-1:0]      r_phase;
    logic signed [COS_W-1:0] r_x;
    logic [WEIGHT_W-1:0]     r_weight;
    logic                    r_last;
    logic [CNT_W-1:0]        r_n;
    logic [KW-1:0]           r_k;
    logic [PW_W-1:0]         r_pw;
    logic [FACT_W-1:0]       r_factor;
    logic signed [P_W-1:0]   r_prev;
    logic signed [P_W-1:0]   r_cur;
    logic [42:0]             r_phi;
    logic [61:0]             r_plo;
    logic signed [63:0]      r_xp;
    logic [TERM_W-1:0]       r_tmag;
    logic                    r_tneg;
    logic signed [T_W-1:0]   r_t;
    logic signed [NUM_W-1:0] r_a1;
    logic signed [NUM_W-1:0] r_a2;
    logic [EP_W-1:0]         r_eprod;
    logic                    r_eneg;
    logic                    r_neg_seen;
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_value;
    logic [IDX_W-1:0]        r_out_index;
    logic                    r_out_last;

    logic [CMP_W-1:0]        cfg_ext;
    logic [CNT_W-1:0]        active_n;
    logic                    k_last;
    logic [KW:0]             two_k1;
    logic [P_W-1:0]          cur_mag;
    logic [63:0]             xp_mag;
    logic [T_W-1:0]          xm;
    logic signed [TERM_W:0]  term_s;
    logic signed [SUM_W-1:0] sum_s;
    logic signed [ACC_W-1:0] acc_new;
    logic signed [ACC_W-1:0] acc_rd;
    logic signed [NUM_W-1:0] k1_s;
    logic signed [NUM_W-1:0] t_s;
    logic signed [NUM_W-1:0] k_s;
    logic signed [NUM_W-1:0] prev_s;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]        num_mag;
    logic [CNT_W-1:0]        divisor;
    logic [NUM_W-1:0]        dividend;
    logic [EP_W-1:0]         half;
    logic [OUT_W-1:0]        coef_val;
    logic                    out_free;
    logic                    out_load;
    logic                    div_start;
    t_mem_ctl                mem_ctl;
    t_div_stat               div_stat;
    logic signed [P_W-1:0]   div_q;

    lme_acc_mem #(
        .DEPTH (MAX_COEFFS),
        .AW    (KW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_addr    (r_k),
        .i_wr_data (acc_new),
        .o_rd_data (acc_rd)
    );

    lme_div #(
        .NUM_W (NUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .i_neg      (num[NUM_W-1]),
        .o_stat     (div_stat),
        .o_quot     (div_q)
    );

    // Active count: zero means one, anything above the memory depth is clipped.
    assign cfg_ext = CMP_W'(r_cfg_count);
    always_comb begin
        if (r_cfg_count == '0) begin
            active_n = CNT_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_COEFFS)) begin
            active_n = CNT_W'(MAX_COEFFS);
        end else begin
            active_n = CNT_W'(cfg_ext);
        end
    end

    assign k_last   = (CNT_W'(r_k) + CNT_W'(1)) == r_n;
    assign two_k1   = {r_k, 1'b1};
    assign cur_mag  = r_cur[P_W-1] ? P_W'(-r_cur) : P_W'(r_cur);
    assign xp_mag   = r_xp[63] ? 64'(-r_xp) : 64'(r_xp);
    assign xm       = T_W'((xp_mag + 64'd536870912) >> 30);

    assign term_s   = r_tneg ? -$signed({1'b0, r_tmag}) : $signed({1'b0, r_tmag});
    assign sum_s    = SUM_W'(acc_rd) + SUM_W'(term_s);
    always_comb begin
        if (sum_s[SUM_W-1] != sum_s[SUM_W-2]) begin
            acc_new = sum_s[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_new = sum_s[ACC_W-1:0];
        end
    end

    assign k1_s     = $signed(NUM_W'(two_k1));
    assign t_s      = NUM_W'(r_t);
    assign k_s      = $signed(NUM_W'(r_k));
    assign prev_s   = NUM_W'(r_prev);
    assign num      = r_a1 - r_a2;
    assign num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign divisor  = CNT_W'(r_k) + CNT_W'(1);
    assign dividend = num_mag + NUM_W'(divisor >> 1);

    assign half     = (r_eprod + EP_W'(1)) >> 1;
    always_comb begin
        if (r_neg_seen || r_eneg) begin
            coef_val = '0;
        end else if (half > EP_W'(OUT_MAX)) begin
            coef_val = OUT_MAX;
        end else begin
            coef_val = OUT_W'(half);
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_FACT;
            S_FACT:  n_state = S_ROUND;
            S_ROUND: n_state = S_RD;
            S_RD:    n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC: begin
                if (k_last) begin
                    n_state = r_last ? S_ERD : S_IDLE;
                end else begin
                    n_state = S_NUM;
                end
            end
            S_NUM:   n_state = S_DIV;
            S_DIV:   if (div_stat.done) n_state = S_RD;
            S_ERD:   n_state = S_EMUL;
            S_EMUL:  n_state = S_EOUT;
            S_EOUT: begin
                if (out_free) begin
                    n_state = k_last ? S_IDLE : S_ERD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall         = (r_state != S_IDLE);
        mem_ctl.rd_en   = (r_state == S_RD) || (r_state == S_ERD);
        mem_ctl.wr_en   = (r_state == S_ACC);
        out_load        = (r_state == S_EOUT) && out_free;
        mem_ctl.clr_all = out_load && k_last;
        div_start       = (r_state == S_NUM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_count <= CFG_RESET;
            r_k         <= '0;
            r_neg_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_cfg_count <= i_cfg_wr_data;
            end
            if (r_state == S_IDLE) begin
                r_k <= '0;
            end else if (r_state == S_ACC && k_last) begin
                r_k <= '0;
            end else if (r_state == S_DIV && div_stat.done) begin
                r_k <= r_k + KW'(1);
            end else if (out_load && !k_last) begin
                r_k <= r_k + KW'(1);
            end
            if (out_load) begin
                if (k_last) begin
                    r_neg_seen <= 1'b0;
                end else if (r_eneg) begin
                    r_neg_seen <= 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_phase  <= i_phase_value;
            r_x      <= i_node_cosine;
            r_weight <= i_node_weight;
            r_last   <= i_last_point;
            r_n      <= active_n;
            r_prev   <= '0;
            r_cur    <= P_ONE;
        end
        if (r_state == S_FACT) begin
            r_pw <= PW_W'(r_phase) * PW_W'(r_weight);
        end
        if (r_state == S_ROUND) begin
            r_factor <= FACT_W'((r_pw + 64'd4194304) >> 23);
        end
        if (r_state == S_RD) begin
            r_phi <= 43'(r_factor[FACT_W-1:30]) * 43'(cur_mag);
            r_plo <= 62'(r_factor[29:0]) * 62'(cur_mag);
            r_xp  <= 64'(r_x) * 64'(r_cur);
        end
        if (r_state == S_MUL) begin
            r_tmag <= TERM_W'(r_phi) + TERM_W'((r_plo + 62'd536870912) >> 30);
            r_tneg <= r_cur[P_W-1];
            r_t    <= r_xp[63] ? -$signed(xm) : $signed(xm);
        end
        if (r_state == S_ACC) begin
            r_a1 <= k1_s * t_s;
            r_a2 <= k_s * prev_s;
        end
        if (r_state == S_DIV && div_stat.done) begin
            r_prev <= r_cur;
            r_cur  <= div_q;
        end
        if (r_state == S_EMUL) begin
            r_eprod <= EP_W'(acc_rd[ACC_W-2:0]) * EP_W'(two_k1);
            r_eneg  <= acc_rd[ACC_W-1];
        end
        if (out_load) begin
            r_out_value <= coef_val;
            r_out_index <= IDX_W'(r_k);
            r_out_last  <= k_last;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_coefficient_value = r_out_value;
    assign o_coefficient_index = r_out_index;
    assign o_last_coefficient  = r_out_last;

    `LME_ASSERT_NOW(a_div_start_idle, div_start, !div_stat.busy, "divider started while busy")
    `LME_ASSERT_NOW(a_order_range, r_state != S_IDLE, CNT_W'(r_k) < r_n, "order past count")
    `LME_ASSERT_NEXT(a_run_end, out_load && k_last, r_state == S_IDLE && !r_neg_seen, "run end")

endmodule

FILE: tb/legendre_moment_expansion_tb.sv
// Self-checking testbench for the Legendre moment expansion block.
`timescale 1ns / 100ps

module legendre_moment_expansion_tb;
    import lme_pkg::*;

    localparam int MAX_N = lme_pkg::MAX_COEFFS_DEF;
    localparam longint ACC_HI = (64'sd1 <<< 55) - 1;
    localparam longint ACC_LO = -(64'sd1 <<< 55);
    localparam longint P_HI = 64'sd2147483647;
    localparam longint P_LO = -64'sd2147483648;
    localparam longint unsigned VAL_HI = (64'd1 << 48) - 1;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 6000;

    typedef struct {
        logic [OUT_W-1:0] value;
        logic [IDX_W-1:0] index;
        logic             last;
    } t_coeff;

    class coefficient_scoreboard;
        longint moments[MAX_N];
        logic [CFG_W-1:0] count_reg;
        t_coeff expected_coeffs[$];
        int errors;

        function new();
            foreach (moments[i]) moments[i] = 0;
            count_reg = CFG_RESET;
            errors = 0;
        endfunction

        function int active_n();
            if (count_reg == 0) return 1;
            if (count_reg > MAX_N) return MAX_N;
            return count_reg;
        endfunction

        function longint unsigned magnitude(longint v);
            return (v < 0) ? longint'(-v) : v;
        endfunction

        function longint with_sign(longint unsigned m, bit neg);
            return neg ? -longint'(m) : longint'(m);
        endfunction

        // Runs the recurrence for one point; on the last point it queues every coefficient.
        function void accumulate_point(logic [31:0] ph, logic [31:0] cs, logic [31:0] wt,
                                       logic lastp);
            longint unsigned factor, pm, hi, lo, m, xm, d, q, v;
            longint x, cur, prev, s, xp, t, num, nx;
            bit neg_seen;
            int n;
            t_coeff c;
            n = active_n();
            x = longint'($signed(cs));
            factor = ({32'd0, ph} * {32'd0, wt} + (64'd1 << 22)) >> 23;
            prev = 0;
            cur = 64'sd1 <<< 30;
            for (int k = 0; k < n; k++) begin
                pm = magnitude(cur);
                hi = factor >> 30;
                lo = factor & ((64'd1 << 30) - 1);
                m = hi * pm + ((lo * pm + (64'd1 << 29)) >> 30);
                s = moments[k] + with_sign(m, cur < 0);
                if (s > ACC_HI) s = ACC_HI;
                if (s < ACC_LO) s = ACC_LO;
                moments[k] = s;
                xp = x * cur;
                xm = (magnitude(xp) + (64'd1 << 29)) >> 30;
                t = with_sign(xm, xp < 0);
                num = longint'(2 * k + 1) * t - longint'(k) * prev;
                d = k + 1;
                q = (magnitude(num) + d / 2) / d;
                nx = with_sign(q, num < 0);
                if (nx > P_HI) nx = P_HI;
                if (nx < P_LO) nx = P_LO;
                prev = cur;
                cur = nx;
            end
            if (!lastp) return;
            neg_seen = 0;
            for (int k = 0; k < n; k++) begin
                v = 0;
                if (!neg_seen) begin
                    if (moments[k] < 0) neg_seen = 1;
                    else begin
                        v = (longint'(moments[k]) * (2 * k + 1) + 1) >> 1;
                        if (v > VAL_HI) v = VAL_HI;
                    end
                end
                c.value = v[OUT_W-1:0];
                c.index = k[IDX_W-1:0];
                c.last = (k + 1 == n);
                expected_coeffs.push_back(c);
            end
            foreach (moments[i]) moments[i] = 0;
        endfunction

        function void check_coeff(logic [OUT_W-1:0] value, logic [IDX_W-1:0] index,
                                  logic lastc);
            t_coeff e;
            if (expected_coeffs.size() == 0) begin
                $error("unexpected coefficient: value %0h index %0d", value, index);
                errors++;
                return;
            end
            e = expected_coeffs.pop_front();
            if (value !== e.value) begin
                $error("coefficient_value: expected %0h actual %0h", e.value, value);
                errors++;
            end
            if (index !== e.index) begin
                $error("coefficient_index: expected %0d actual %0d", e.index, index);
                errors++;
            end
            if (lastc !== e.last) begin
                $error("last_coefficient: expected %0b actual %0b", e.last, lastc);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [CFG_W-1:0]         i_cfg_wr_data;
    logic                     i_valid;
    logic                     o_stall;
    logic [PHASE_W-1:0]       i_phase_value;
    logic signed [COS_W-1:0]  i_node_cosine;
    logic [WEIGHT_W-1:0]      i_node_weight;
    logic                     i_last_point;
    logic                     o_valid;
    logic                     i_stall;
    logic [OUT_W-1:0]         o_coefficient_value;
    logic [IDX_W-1:0]         o_coefficient_index;
    logic                     o_last_coefficient;

    coefficient_scoreboard sb;
    bit hold_request;
    int points_sent;

    legendre_moment_expansion dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_phase_value(i_phase_value), .i_node_cosine(i_node_cosine),
        .i_node_weight(i_node_weight), .i_last_point(i_last_point),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_coefficient_value(o_coefficient_value),
        .o_coefficient_index(o_coefficient_index),
        .o_last_coefficient(o_last_coefficient)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_point(logic [31:0] ph, logic [31:0] cs, logic [31:0] wt, logic lastp);
        int gap;
        bit ok;
        gap = random_gap();
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_phase_value <= ph;
        i_node_cosine <= cs;
        i_node_weight <= wt;
        i_last_point <= lastp;
        do begin
            @(negedge i_clk);
            ok = !o_stall;
            @(posedge i_clk);
        end while (!ok);
        sb.accumulate_point(ph, cs, wt, lastp);
        points_sent++;
    endtask

    // Waits until the block has drained, then writes the count register.
    task automatic write_count(logic [CFG_W-1:0] val);
        i_valid <= 0;
        while (sb.expected_coeffs.size() != 0) @(posedge i_clk);
        repeat (6 + 39 * sb.active_n() + 30) @(posedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        sb.count_reg = val;
    endtask

    function logic [31:0] rand_cosine();
        return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    endfunction

    function logic [31:0] rand_weight();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 32'h8000_0000);
        return $urandom_range(0, 32'h0400_0000);
    endfunction

    // Receiver side: random stalls, plus one long hold-off on request.
    initial begin
        i_stall <= 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_stall <= 1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 0;
                i_stall <= 0;
            end else begin
                i_stall <= (random_gap() > 0);
            end
        end
    end

    // Output monitor: sample at the falling edge, check at the rising edge.
    initial begin
        bit fire;
        logic [OUT_W-1:0] v;
        logic [IDX_W-1:0] idx;
        logic lc;
        forever begin
            @(negedge i_clk);
            fire = i_rst_n && o_valid && !i_stall;
            v = o_coefficient_value;
            idx = o_coefficient_index;
            lc = o_last_coefficient;
            @(posedge i_clk);
            if (fire) sb.check_coeff(v, idx, lc);
        end
    end

    // Watchdog on cycles without any accepted item on either side.
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(negedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int n_seq, len;
        logic [CFG_W-1:0] cnt;
        logic [31:0] base_wt;
        bit pressure_done;
        sb = new();
        points_sent = 0;
        hold_request = 0;
        pressure_done = 0;
        i_rst_n <= 0;
        i_cfg_wr_en <= 0;
        i_cfg_wr_data <= '0;
        i_valid <= 0;
        i_phase_value <= '0;
        i_node_cosine <= '0;
        i_node_weight <= '0;
        i_last_point <= 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Reset count of 64, extremes of phase and cosine.
        send_point(32'h0001_0000, 32'h0, 32'h8000_0000, 0);
        send_point(32'hFFFF_FFFF, 32'h4000_0000, 32'h8000_0000, 1);
        // A count of zero acts as one coefficient.
        write_count(7'd0);
        send_point(32'h0, 32'h0, 32'h0, 1);
        send_point(32'hFFFF_FFFF, 32'hC000_0000, 32'h8000_0000, 1);
        // Cosines outside [-1,1] push P into saturation.
        write_count(7'd5);
        send_point(32'h0002_0000, 32'hC000_0000, 32'h4000_0000, 0);
        send_point(32'h0003_0000, 32'h7FFF_FFFF, 32'h2000_0000, 0);
        send_point(32'h0001_8000, 32'h8000_0000, 32'h1000_0000, 1);
        send_point(32'h0, 32'h2000_0000, 32'h8000_0000, 1);
        // Count lowered between the points of one run.
        send_point(32'h0005_0000, 32'h1000_0000, 32'h0800_0000, 0);
        write_count(7'd3);
        send_point(32'h0004_0000, 32'hF000_0000, 32'h0800_0000, 1);
        // A count above the maximum is taken as the maximum.
        write_count(7'd127);
        send_point(32'h0000_8000, 32'h3000_0000, 32'h0100_0000, 1);

        while (points_sent < 210) begin
            case ($urandom_range(0, 19))
                0: cnt = 7'd64;
                1: cnt = ($urandom_range(0, 1) != 0) ? 7'd0 : 7'd127;
                2, 3: cnt = CFG_W'($urandom_range(9, 20));
                default: cnt = CFG_W'($urandom_range(1, 8));
            endcase
            write_count(cnt);
            n_seq = (cnt >= 20 && cnt != 127) ? 1 : $urandom_range(2, 5);
            for (int s = 0; s < n_seq; s++) begin
                if (!pressure_done && points_sent > 100 && cnt >= 4 && cnt <= 19) begin
                    hold_request = 1;
                    pressure_done = 1;
                end
                len = $urandom_range(1, 4);
                base_wt = rand_weight();
                for (int p = 0; p < len; p++) begin
                    // Occasionally a run with a broken weight or a stray last mark.
                    if ($urandom_range(0, 9) == 0)
                        send_point($urandom, rand_cosine(), $urandom_range(0, 32'h8000_0000),
                                   1'($urandom_range(0, 1)));
                    else
                        send_point($urandom, rand_cosine(), base_wt ^ $urandom_range(0, 255),
                                   p == len - 1);
                end
            end
            if (sb.expected_coeffs.size() == 0) send_point($urandom, rand_cosine(),
                                                           rand_weight(), 1);
        end
        i_valid <= 0;

        while (sb.expected_coeffs.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_coeffs.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/lme_pkg.sv
hw/rtl/lme_acc_mem.sv
hw/rtl/lme_div.sv
hw/rtl/legendre_moment_expansion.sv
tb/legendre_moment_expansion_tb.sv
